// ===== design/hslc_pkg.sv =====
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared types, result codes and character constants for the status line
// checker.
// ----------------------------------------------------------------------------
package hslc_pkg;

  typedef logic [3:0]  result_code_t;
  typedef logic [7:0]  char_t;
  typedef logic [10:0] line_len_t;

  // Result codes
  localparam result_code_t RC_OK            = 4'd0;
  localparam result_code_t RC_NUL           = 4'd1;
  localparam result_code_t RC_NON_ASCII     = 4'd2;
  localparam result_code_t RC_TOO_LONG      = 4'd3;
  localparam result_code_t RC_NO_CRLF       = 4'd4;
  localparam result_code_t RC_NO_SPACES     = 4'd5;
  localparam result_code_t RC_BAD_VERSION   = 4'd6;
  localparam result_code_t RC_CODE_LENGTH   = 4'd7;
  localparam result_code_t RC_CODE_NONDIGIT = 4'd8;

  // Characters
  localparam char_t CHAR_NUL   = 8'h00;
  localparam char_t CHAR_LF    = 8'h0A;
  localparam char_t CHAR_CR    = 8'h0D;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_DOT   = 8'h2E;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;

  // Line length limits
  localparam line_len_t COUNT_CAP       = 11'd2047;
  localparam line_len_t MAX_LINE_RESET  = 11'd1024;

  // Version prefix and code token length
  localparam logic [2:0] PREFIX_LEN  = 3'd5;
  localparam logic [2:0] CODE_DIGITS = 3'd3;
  localparam logic [2:0] CODE_LEN_CAP = 3'd7;

  // Characters of the version prefix "HTTP/"
  function automatic char_t prefix_char(input logic [2:0] idx);
    char_t c;
    unique case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== design/http_status_line_checker.sv =====
// ----------------------------------------------------------------------------
// http_status_line_checker
// Checks one response status line per transaction sequence, byte by byte,
// and emits one result at the terminating byte.
// ----------------------------------------------------------------------------
// Result path: an ending byte is first held in the input register; the result
//   register then loads from it when the byte advances, which a stalled result
//   register (out_valid with out_stall) can hold off.
// Throughput: one byte per cycle while no ending byte waits on a stalled result;
//   each byte updates counters and flags in one pass between the input and result registers.
// Reset: rst clears all line state and both registers' valid flags and sets
//   max_line_length to 1024.
module http_status_line_checker
  import hslc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_write,
  input  logic [10:0]  cfg_data,
  // byte input
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   data_byte,
  // result output
  output logic         out_valid,
  input  logic         out_stall,
  output logic [3:0]   result_code,
  output logic [9:0]   status_code,
  output logic [10:0]  consumed_length
);

  // Version parser phases
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_MAJOR  = 2'd1;
  localparam logic [1:0] PH_MINOR  = 2'd2;
  localparam logic [1:0] PH_BAD    = 2'd3;

  localparam logic [31:0] INT_CAP = 32'h7FFF_FFFF;

  logic        [10:0] max_line_length;

  // Input register
  logic               s1_valid;
  char_t              s1_byte;

  // Line state
  logic        [10:0] byte_count;
  logic        [1:0]  space_count;
  logic               prev_was_cr;
  logic        [1:0]  version_phase;
  logic        [2:0]  prefix_index;
  logic        [31:0] major_value;
  logic               major_seen;
  logic               major_ovf;
  logic        [31:0] minor_value;
  logic               minor_seen;
  logic               minor_ovf;
  logic        [9:0]  code_value;
  logic        [2:0]  code_length;
  logic               code_all_digits;

  // Byte classification
  logic               is_space;
  logic               is_lf;
  logic               is_bad_char;
  logic               is_digit;
  logic        [3:0]  digit_val;
  logic               emits;
  logic               advance;

  logic        [11:0] len_inc;
  logic        [10:0] len_sat;

  logic        [34:0] major_mul;
  logic        [34:0] minor_mul;
  logic        [13:0] code_mul;
  logic               major_mul_ovf;
  logic               minor_mul_ovf;
  logic               version_ok;

  result_code_t       res_code;
  logic        [9:0]  res_status;
  logic        [10:0] res_len;

  // Classify the staged byte
  assign is_space    = (s1_byte == CHAR_SPACE);
  assign is_lf       = (s1_byte == CHAR_LF);
  assign is_bad_char = (s1_byte == CHAR_NUL) || s1_byte[7];
  assign is_digit    = (s1_byte >= CHAR_ZERO) && (s1_byte <= CHAR_NINE);
  assign digit_val   = s1_byte[3:0];
  assign emits       = is_bad_char || is_lf;

  // Advance when the result register can take a result, or none is made
  assign advance  = s1_valid && (!emits || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Saturating length including the current byte
  assign len_inc = {1'b0, byte_count} + 12'd1;
  assign len_sat = len_inc[11] ? COUNT_CAP : len_inc[10:0];

  // Decimal accumulate: x*10 + d by shift and add
  assign major_mul = ({3'b000, major_value} << 3) + ({3'b000, major_value} << 1)
                   + {31'd0, digit_val};
  assign minor_mul = ({3'b000, minor_value} << 3) + ({3'b000, minor_value} << 1)
                   + {31'd0, digit_val};
  assign code_mul  = ({4'd0, code_value} << 3) + ({4'd0, code_value} << 1)
                   + {10'd0, digit_val};
  assign major_mul_ovf = |major_mul[34:31];
  assign minor_mul_ovf = |minor_mul[34:31];

  // Version passes at 1.1 and up, or any major of 2 and up
  assign version_ok = (version_phase == PH_MINOR)
                   && major_seen && !major_ovf && minor_seen && !minor_ovf
                   && (((|major_value) && (|minor_value)) || (|major_value[31:1]));

  // Result of an ending byte, checks in priority order
  always_comb begin
    res_code   = RC_OK;
    res_status = 10'd0;
    res_len    = len_sat;
    if (is_bad_char) begin
      res_code = (s1_byte == CHAR_NUL) ? RC_NUL : RC_NON_ASCII;
    end else if (byte_count >= max_line_length) begin
      res_code = RC_TOO_LONG;
      res_len  = max_line_length;
    end else if (!prev_was_cr) begin
      res_code = RC_NO_CRLF;
    end else if (space_count < 2'd2) begin
      res_code = RC_NO_SPACES;
    end else if (!version_ok) begin
      res_code = RC_BAD_VERSION;
    end else if (code_length != CODE_DIGITS) begin
      res_code = RC_CODE_LENGTH;
    end else if (!code_all_digits) begin
      res_code = RC_CODE_NONDIGIT;
    end else begin
      res_status = code_value;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= MAX_LINE_RESET;
    end else if (cfg_write) begin
      max_line_length <= cfg_data;
    end
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= data_byte;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emits) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance && emits) begin
      result_code     <= res_code;
      status_code     <= res_status;
      consumed_length <= res_len;
    end
  end

  // Line state: update on each byte, clear after an ending byte
  always_ff @(posedge clk) begin
    if (rst || (advance && emits)) begin
      byte_count      <= 11'd0;
      space_count     <= 2'd0;
      prev_was_cr     <= 1'b0;
      version_phase   <= PH_PREFIX;
      prefix_index    <= 3'd0;
      major_value     <= 32'd0;
      major_seen      <= 1'b0;
      major_ovf       <= 1'b0;
      minor_value     <= 32'd0;
      minor_seen      <= 1'b0;
      minor_ovf       <= 1'b0;
      code_value      <= 10'd0;
      code_length     <= 3'd0;
      code_all_digits <= 1'b1;
    end else if (advance) begin
      byte_count <= len_sat;
      if (is_space) begin
        if (space_count < 2'd2) begin
          space_count <= space_count + 2'd1;
        end
        prev_was_cr <= 1'b0;
      end else begin
        prev_was_cr <= (s1_byte == CHAR_CR);
        if (space_count == 2'd0) begin
          // Version token
          case (version_phase)
            PH_PREFIX: begin
              if (s1_byte == prefix_char(prefix_index)) begin
                prefix_index <= prefix_index + 3'd1;
                if (prefix_index == PREFIX_LEN - 3'd1) begin
                  version_phase <= PH_MAJOR;
                end
              end else begin
                version_phase <= PH_BAD;
              end
            end
            PH_MAJOR: begin
              if (is_digit) begin
                major_seen <= 1'b1;
                if (major_mul_ovf) begin
                  major_ovf   <= 1'b1;
                  major_value <= INT_CAP;
                end else begin
                  major_value <= major_mul[31:0];
                end
              end else if (s1_byte == CHAR_DOT) begin
                version_phase <= PH_MINOR;
              end else begin
                version_phase <= PH_BAD;
              end
            end
            PH_MINOR: begin
              if (is_digit) begin
                minor_seen <= 1'b1;
                if (minor_mul_ovf) begin
                  minor_ovf   <= 1'b1;
                  minor_value <= INT_CAP;
                end else begin
                  minor_value <= minor_mul[31:0];
                end
              end else begin
                version_phase <= PH_BAD;
              end
            end
            default: begin
              version_phase <= PH_BAD;
            end
          endcase
        end else if (space_count == 2'd1) begin
          // Status code token
          if (!is_digit) begin
            code_all_digits <= 1'b0;
          end else if (code_length < CODE_DIGITS) begin
            code_value <= code_mul[9:0];
          end
          if (code_length < CODE_LEN_CAP) begin
            code_length <= code_length + 3'd1;
          end
        end
      end
    end
  end

  // Checks
  a_status_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_code != RC_OK)) |-> (status_code == 10'd0))
    else $error("status code set on a failed line");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && emits) |=> ((byte_count == 11'd0) && (space_count == 2'd0)
                            && code_all_digits))
    else $error("line state not cleared after ending byte");

  a_space_sat: assert property (@(posedge clk) disable iff (rst)
    space_count != 2'd3)
    else $error("space count past saturation");

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && emits && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_ok_has_line: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_code == RC_OK)) |-> (consumed_length > 11'd2))
    else $error("ok result on too short a line");

endmodule
